FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, keyword table and character classes for the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int LCB_DEFAULT    = 16;
    localparam int KW_MAX_DEFAULT = 9;
    localparam int MAX_RES        = 6;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [6:0] K_IDENT   = 7'd32;
    localparam logic [6:0] K_NUMBER  = 7'd33;
    localparam logic [6:0] K_STRING  = 7'd34;
    localparam logic [6:0] K_UNKNOWN = 7'd77;
    localparam logic [6:0] K_END     = 7'd78;

    localparam logic [71:0] KW_STR [32] = '{
        "degisken", "sabit", "eger", "degilse", "yoksa", "dongu", "icin", "sure",
        "dondur", "kirkitla", "devam", "fonksiyon", "sinif", "yeni", "bu", "miras",
        "arayuz", "geridor", "yazdir", "oku", "dahilet", "cikis", "dogru", "yanlis",
        "tanimsiz", "sayi", "metin", "bool", "bos", "liste", "sozluk", "otomatik"
    };

    localparam logic [3:0] KW_LEN [32] = '{
        4'd8, 4'd5, 4'd4, 4'd7, 4'd5, 4'd5, 4'd4, 4'd4,
        4'd6, 4'd8, 4'd5, 4'd9, 4'd5, 4'd4, 4'd2, 4'd5,
        4'd6, 4'd7, 4'd6, 4'd3, 4'd7, 4'd5, 4'd5, 4'd6,
        4'd8, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd6, 4'd8
    };

    typedef struct packed {
        logic [6:0] kind;
        logic       two;
    } op_t;

    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
        logic [3:0] pos;
        pos = KW_LEN[k] - 4'd1 - i;
        if (i < KW_LEN[k])
            return KW_STR[k][{pos, 3'b000} +: 8];
        return 8'd0;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic ident_start(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               (c == "_") || c[7];
    endfunction

    function automatic logic ident_char(input logic [7:0] c);
        return ident_start(c) || is_digit(c);
    endfunction

    function automatic op_t op_kind(input logic [7:0] c, input logic [7:0] n);
        op_t r;
        r.two  = 1'b0;
        r.kind = K_UNKNOWN;
        unique case (c)
            "+": begin
                r.two = (n == "+") || (n == "=");
                r.kind = (n == "+") ? 7'd35 : (n == "=") ? 7'd36 : 7'd37;
            end
            "-": begin
                r.two = (n == "-") || (n == "=") || (n == ">");
                r.kind = (n == "-") ? 7'd38 : (n == "=") ? 7'd39 :
                         (n == ">") ? 7'd40 : 7'd41;
            end
            "*": begin
                r.two = (n == "*") || (n == "=");
                r.kind = (n == "*") ? 7'd42 : (n == "=") ? 7'd43 : 7'd44;
            end
            "/": begin r.two = (n == "="); r.kind = r.two ? 7'd45 : 7'd46; end
            "%": begin r.two = (n == "="); r.kind = r.two ? 7'd47 : 7'd48; end
            "=": begin r.two = (n == "="); r.kind = r.two ? 7'd49 : 7'd50; end
            "!": begin r.two = (n == "="); r.kind = r.two ? 7'd51 : 7'd52; end
            "<": begin
                r.two = (n == "=") || (n == "<");
                r.kind = (n == "=") ? 7'd53 : (n == "<") ? 7'd54 : 7'd55;
            end
            ">": begin
                r.two = (n == "=") || (n == ">");
                r.kind = (n == "=") ? 7'd56 : (n == ">") ? 7'd57 : 7'd58;
            end
            "&": begin r.two = (n == "&"); r.kind = r.two ? 7'd59 : 7'd60; end
            "|": begin r.two = (n == "|"); r.kind = r.two ? 7'd61 : 7'd62; end
            ":": begin r.two = (n == ":"); r.kind = r.two ? 7'd74 : 7'd75; end
            "~": r.kind = 7'd63;
            "^": r.kind = 7'd64;
            "(": r.kind = 7'd65;
            ")": r.kind = 7'd66;
            "{": r.kind = 7'd67;
            "}": r.kind = 7'd68;
            "[": r.kind = 7'd69;
            "]": r.kind = 7'd70;
            ";": r.kind = 7'd71;
            ",": r.kind = 7'd72;
            ".": r.kind = 7'd73;
            "?": r.kind = 7'd76;
            default: r.kind = K_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Lexer state machine: takes one source byte per cycle while the bundle queue is not
// full and builds the bundle of result items that byte causes.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int LINE_COL_BITS = stt_pkg::LCB_DEFAULT,
    parameter int KW_MAX_LEN    = stt_pkg::KW_MAX_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      in_func,
    input  logic [7:0]                                in_byte,
    input  logic                                      q_full,
    output logic                                      q_push,
    output logic [stt_pkg::MAX_RES*(2*LINE_COL_BITS+17)+2:0] q_data
);
    import stt_pkg::*;

    localparam int L  = LINE_COL_BITS;
    localparam int LW = $clog2(KW_MAX_LEN + 1);
    localparam logic [L-1:0] LC_MAX = {L{1'b1}};
    localparam logic [L-1:0] LC_ONE = L'(1);

    typedef struct packed {
        logic [6:0]   kind;
        logic [L-1:0] line;
        logic [L-1:0] col;
        logic [7:0]   vbyte;
        logic         bv;
        logic         done;
    } item_t;

    typedef struct packed {
        logic [2:0]                cnt;
        item_t [MAX_RES-1:0]       items;
    } bundle_t;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_STR, M_ESC, M_LINEC, M_BOPEN, M_BLOCK, M_SKIP
    } mode_t;

    logic [7:0]    held_byte_reg, held_byte_next;
    logic          held_valid_reg, held_valid_next;
    mode_t         mode_reg, mode_next;
    logic [L-1:0]  cur_line_reg, cur_line_next;
    logic [L-1:0]  cur_col_reg, cur_col_next;
    logic [L-1:0]  tok_line_reg, tok_line_next;
    logic [L-1:0]  tok_col_reg, tok_col_next;
    logic [31:0]   kc_reg, kc_next;
    logic [LW-1:0] il_reg, il_next;
    logic          dot_reg, dot_next;

    bundle_t       bun;
    logic          accept;
    logic [7:0]    c;
    logic [7:0]    la;
    logic          fall;
    op_t           op;

    function automatic item_t mk(input logic [6:0] kind, input logic [L-1:0] line,
                                 input logic [L-1:0] col, input logic [7:0] b,
                                 input logic bv, input logic done);
        item_t r;
        r.kind  = kind;
        r.line  = line;
        r.col   = col;
        r.vbyte = b;
        r.bv    = bv;
        r.done  = done;
        return r;
    endfunction

    function automatic logic [31:0] kw_upd(input logic [31:0] kc, input logic [LW-1:0] il,
                                           input logic [7:0] ch);
        logic [31:0] r;
        logic [7:0]  e;
        r = kc;
        for (int k = 0; k < 32; k++) begin
            e = (il < LW'(KW_MAX_LEN)) ? kw_char(5'(k), il[3:0]) : 8'd0;
            if (e != ch)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [6:0] kw_kind(input logic [31:0] kc, input logic [LW-1:0] il);
        logic [6:0] r;
        logic       found;
        r = K_IDENT;
        found = 1'b0;
        for (int k = 0; k < 32; k++) begin
            if (!found && kc[k] &&
                ((il >= LW'(KW_MAX_LEN)) || (kw_char(5'(k), il[3:0]) == 8'd0))) begin
                r = 7'(k);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (bun.cnt != 3'd0);
    assign q_data   = bun;

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        mode_next       = mode_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        tok_line_next   = tok_line_reg;
        tok_col_next    = tok_col_reg;
        kc_next         = kc_reg;
        il_next         = il_reg;
        dot_next        = dot_reg;
        bun             = '0;
        c               = held_byte_reg;
        la              = in_func ? 8'd0 : in_byte;
        fall            = 1'b0;
        op              = op_kind(c, la);

        if (held_valid_reg) begin
            unique case (mode_next)
                M_IDENT: begin
                    if (ident_char(c)) begin
                        kc_next = kw_upd(kc_next, il_next, c);
                        if (il_next < LW'(KW_MAX_LEN))
                            il_next = il_next + LW'(1);
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else begin
                        bun.items[bun.cnt] = mk(kw_kind(kc_next, il_next), tok_line_next,
                                                tok_col_next, 8'd0, 1'b0, 1'b1);
                        bun.cnt = bun.cnt + 3'd1;
                        fall = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(c) || ((c == ".") && !dot_next && is_digit(la))) begin
                        if (c == ".")
                            dot_next = 1'b1;
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else begin
                        bun.items[bun.cnt] = mk(K_NUMBER, tok_line_next, tok_col_next,
                                                8'd0, 1'b0, 1'b1);
                        bun.cnt = bun.cnt + 3'd1;
                        fall = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        bun.items[bun.cnt] = mk(K_STRING, tok_line_next, tok_col_next,
                                                8'd0, 1'b0, 1'b1);
                        bun.cnt = bun.cnt + 3'd1;
                        mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_ESC;
                    end else begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end
                end
                M_ESC: begin
                    mode_next = M_STR;
                    if (c == "n") begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next,
                                                8'h0A, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else if (c == "t") begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next,
                                                8'h09, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else if ((c == "\"") || (c == "\\")) begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next,
                                                "\\", 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end
                end
                M_LINEC: begin
                    if (c == 8'h0A)
                        fall = 1'b1;
                end
                M_BOPEN: mode_next = M_BLOCK;
                M_BLOCK: begin
                    if ((c == "*") && (la == "/"))
                        mode_next = M_SKIP;
                end
                M_SKIP: mode_next = M_IDLE;
                default: fall = 1'b1;
            endcase

            if (fall) begin
                mode_next = M_IDLE;
                if (is_space(c)) begin
                    // position only
                end else if ((c == "/") && ((la == "/") || (la == "*"))) begin
                    mode_next = (la == "/") ? M_LINEC : M_BOPEN;
                end else begin
                    tok_line_next = cur_line_next;
                    tok_col_next  = cur_col_next;
                    if (c == "\"") begin
                        mode_next = M_STR;
                    end else if (is_digit(c)) begin
                        mode_next = M_NUM;
                        dot_next  = 1'b0;
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else if (ident_start(c)) begin
                        mode_next = M_IDENT;
                        kc_next   = kw_upd({32{1'b1}}, LW'(0), c);
                        il_next   = LW'(1);
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                    end else begin
                        bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next, c, 1'b1, 1'b0);
                        bun.cnt = bun.cnt + 3'd1;
                        if (op.two) begin
                            bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next,
                                                    la, 1'b1, 1'b0);
                            bun.cnt = bun.cnt + 3'd1;
                            mode_next = M_SKIP;
                        end
                        bun.items[bun.cnt] = mk(op.kind, tok_line_next, tok_col_next,
                                                8'd0, 1'b0, 1'b1);
                        bun.cnt = bun.cnt + 3'd1;
                    end
                end
            end

            // every consumed byte moves the position
            if (c == 8'h0A) begin
                if (cur_line_next != LC_MAX)
                    cur_line_next = cur_line_next + LC_ONE;
                cur_col_next = LC_ONE;
            end else if (cur_col_next != LC_MAX) begin
                cur_col_next = cur_col_next + LC_ONE;
            end
        end

        if (in_func) begin
            unique case (mode_next)
                M_IDENT: begin
                    bun.items[bun.cnt] = mk(kw_kind(kc_next, il_next), tok_line_next,
                                            tok_col_next, 8'd0, 1'b0, 1'b1);
                    bun.cnt = bun.cnt + 3'd1;
                end
                M_NUM: begin
                    bun.items[bun.cnt] = mk(K_NUMBER, tok_line_next, tok_col_next,
                                            8'd0, 1'b0, 1'b1);
                    bun.cnt = bun.cnt + 3'd1;
                end
                M_STR: begin
                    bun.items[bun.cnt] = mk(K_STRING, tok_line_next, tok_col_next,
                                            8'd0, 1'b0, 1'b1);
                    bun.cnt = bun.cnt + 3'd1;
                end
                M_ESC: begin
                    bun.items[bun.cnt] = mk(7'd0, tok_line_next, tok_col_next,
                                            "\\", 1'b1, 1'b0);
                    bun.cnt = bun.cnt + 3'd1;
                    bun.items[bun.cnt] = mk(K_STRING, tok_line_next, tok_col_next,
                                            8'd0, 1'b0, 1'b1);
                    bun.cnt = bun.cnt + 3'd1;
                end
                default: ;
            endcase
            bun.items[bun.cnt] = mk(K_END, cur_line_next, cur_col_next, 8'd0, 1'b0, 1'b1);
            bun.cnt = bun.cnt + 3'd1;

            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            mode_next       = M_IDLE;
            cur_line_next   = LC_ONE;
            cur_col_next    = LC_ONE;
            tok_line_next   = LC_ONE;
            tok_col_next    = LC_ONE;
            kc_next         = {32{1'b1}};
            il_next         = '0;
            dot_next        = 1'b0;
        end else begin
            held_byte_next  = in_byte;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            mode_reg       <= M_IDLE;
            cur_line_reg   <= LC_ONE;
            cur_col_reg    <= LC_ONE;
            tok_line_reg   <= LC_ONE;
            tok_col_reg    <= LC_ONE;
            kc_reg         <= {32{1'b1}};
            il_reg         <= '0;
            dot_reg        <= 1'b0;
        end else if (accept) begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            mode_reg       <= mode_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            tok_line_reg   <= tok_line_next;
            tok_col_reg    <= tok_col_next;
            kc_reg         <= kc_next;
            il_reg         <= il_next;
            dot_reg        <= dot_next;
        end
    end

endmodule

FILE: sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Small register queue of result bundles between lexer and output stage.
// ----------------------------------------------------------------------------
module stt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next  = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            cnt_next = cnt_next + CW'(1);
        end
        if (do_pop) begin
            rd_next  = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            cnt_next = cnt_next - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Output stage: sends the items of the head bundle one per request.
// ----------------------------------------------------------------------------
module stt_back #(
    parameter int LINE_COL_BITS = stt_pkg::LCB_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      head_valid,
    input  logic [stt_pkg::MAX_RES*(2*LINE_COL_BITS+17)+2:0] head_data,
    output logic                                      pop,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [((2*LINE_COL_BITS+22)/8)*8-1:0]     out_data,
    output logic [1:0]                                out_user,
    output logic                                      out_last
);
    import stt_pkg::*;

    localparam int L  = LINE_COL_BITS;
    localparam int DW = ((2*L+22)/8)*8;

    typedef struct packed {
        logic [6:0]   kind;
        logic [L-1:0] line;
        logic [L-1:0] col;
        logic [7:0]   vbyte;
        logic         bv;
        logic         done;
    } item_t;

    typedef struct packed {
        logic [2:0]          cnt;
        item_t [MAX_RES-1:0] items;
    } bundle_t;

    bundle_t    bun;
    item_t      cur;
    logic [2:0] idx_reg, idx_next;
    logic       fin;

    assign bun       = head_data;
    assign cur       = bun.items[idx_reg];
    assign fin       = (idx_reg == bun.cnt - 3'd1);
    assign out_valid = head_valid;
    assign out_data  = DW'({cur.vbyte, cur.col, cur.line, cur.kind});
    assign out_user  = {cur.done, cur.bv};
    assign out_last  = fin;
    assign pop       = out_valid && out_ready && fin;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
            idx_next = fin ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 3'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

FILE: sv/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: bytes in, token text bytes and closing items out.
// ----------------------------------------------------------------------------
// throughput: one source byte per cycle while the bundle queue has room
// each byte leaves 0 to 4 result items, sent by the output stage one per ready cycle
// path: the bundle built when a request is taken waits behind earlier queued bundles
// the output stage and its 4-deep bundle queue set the sustained rate
// reset: asynchronous, returns to the start of a source (line 1, column 1)
module source_text_tokenizer #(
    parameter int LINE_COL_BITS = stt_pkg::LCB_DEFAULT,
    parameter int KW_MAX_LEN    = stt_pkg::KW_MAX_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // in_byte
    input  logic                                  s_axis_tuser,   // func
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tok_kind, start_line, start_col, value_byte, zero fill
    output logic [((2*LINE_COL_BITS+22)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]                            m_axis_tuser,   // byte_valid, tok_done
    output logic                                  m_axis_tlast
);
    import stt_pkg::*;

    localparam int BW = MAX_RES*(2*LINE_COL_BITS+17)+3;

    logic          q_full;
    logic          q_push;
    logic [BW-1:0] q_in;
    logic          q_pop;
    logic          q_valid;
    logic [BW-1:0] q_head;

    stt_front #(
        .LINE_COL_BITS(LINE_COL_BITS),
        .KW_MAX_LEN   (KW_MAX_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_func (s_axis_tuser),
        .in_byte (s_axis_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    stt_queue #(
        .WIDTH(BW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_data (q_head)
    );

    stt_back #(
        .LINE_COL_BITS(LINE_COL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(q_valid),
        .head_data (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
